// ===== src/iphfe_pkg.sv =====
// shared types and constants for the ipv4 header field extractor
package iphfe_pkg;

  localparam int unsigned LINK_HEADER_BYTES = 14;

  localparam logic [15:0] ETHERTYPE_POS  = 16'd12;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] FRAG_MORE      = 16'h2000;
  localparam logic [15:0] FRAG_OFFSET    = 16'h1FFF;
  localparam logic [7:0]  PROTO_GRE      = 8'd47;
  localparam logic [3:0]  IHL_MASK       = 4'hF;
  localparam logic [15:0] POS_MAX        = 16'hFFFF;

  localparam logic [15:0] VL_POS    = 16'(LINK_HEADER_BYTES);
  localparam logic [15:0] FRAG_POS  = 16'(LINK_HEADER_BYTES + 6);
  localparam logic [15:0] PROTO_POS = 16'(LINK_HEADER_BYTES + 9);
  localparam logic [15:0] SRC_POS   = 16'(LINK_HEADER_BYTES + 12);
  localparam logic [15:0] DST_POS   = 16'(LINK_HEADER_BYTES + 16);

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        frame_end;
    logic [2:0]  packet_class;
    logic [31:0] interface_index;
  } in_item_t;

  typedef struct packed {
    logic        event_valid;
    logic [15:0] kept_length;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [31:0] port_word;
    logic [2:0]  event_class;
    logic [31:0] event_interface;
  } out_item_t;

  // one finished frame, classified but not yet formatted
  typedef struct packed {
    logic        keep;
    logic [15:0] length;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ports;
    logic [2:0]  pclass;
    logic [31:0] ifindex;
  } frame_rec_t;

endpackage

// ===== src/iphfe_capture.sv =====
// front part: byte counter, header capture and frame classification
module iphfe_capture import iphfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  in_item_t   item,
  output logic       rec_push,
  output frame_rec_t rec
);

  logic [15:0] pos;
  logic [15:0] ether_kind, ether_kind_next;
  logic [15:0] fragment_word, fragment_word_next;
  logic [7:0]  version_length, version_length_next;
  logic [7:0]  proto_seen, proto_seen_next;
  logic [31:0] source_seen, source_seen_next;
  logic [31:0] dest_seen, dest_seen_next;
  logic [31:0] ports_seen, ports_seen_next;
  logic [3:0]  ihl;
  logic [15:0] start;
  logic [15:0] port_off, src_off, dst_off;
  logic [7:0]  b;

  function automatic logic [31:0] put_byte(logic [31:0] word, logic [1:0] idx,
                                           logic [7:0] v);
    logic [31:0] w;
    w = word;
    case (idx)
      2'd0:    w[31:24] = v;
      2'd1:    w[23:16] = v;
      2'd2:    w[15:8]  = v;
      default: w[7:0]   = v;
    endcase
    return w;
  endfunction

  assign b        = item.data_byte;
  assign ihl      = ((pos == VL_POS) ? b[3:0] : version_length[3:0]) & IHL_MASK;
  assign start    = VL_POS + {10'd0, ihl, 2'b00};
  assign port_off = pos - start;
  assign src_off  = pos - SRC_POS;
  assign dst_off  = pos - DST_POS;

  always_comb begin
    ether_kind_next     = ether_kind;
    fragment_word_next  = fragment_word;
    version_length_next = version_length;
    proto_seen_next     = proto_seen;
    source_seen_next    = source_seen;
    dest_seen_next      = dest_seen;
    ports_seen_next     = ports_seen;
    if (pos == ETHERTYPE_POS) begin
      ether_kind_next[15:8] = b;
    end else if (pos == ETHERTYPE_POS + 16'd1) begin
      ether_kind_next[7:0] = b;
    end
    if (pos == VL_POS) begin
      version_length_next = b;
    end
    if (pos == FRAG_POS) begin
      fragment_word_next[15:8] = b;
    end else if (pos == FRAG_POS + 16'd1) begin
      fragment_word_next[7:0] = b;
    end
    if (pos == PROTO_POS) begin
      proto_seen_next = b;
    end
    if (pos >= SRC_POS && pos < SRC_POS + 16'd4) begin
      source_seen_next = put_byte(source_seen, src_off[1:0], b);
    end
    if (pos >= DST_POS && pos < DST_POS + 16'd4) begin
      dest_seen_next = put_byte(dest_seen, dst_off[1:0], b);
    end
    if (pos >= start && pos < start + 16'd4) begin
      ports_seen_next = put_byte(ports_seen, port_off[1:0], b);
    end
  end

  always_comb begin
    rec_push    = take && item.frame_end;
    rec.keep    = (ether_kind_next == ETHERTYPE_IPV4) &&
                  ((fragment_word_next & (FRAG_MORE | FRAG_OFFSET)) == 16'd0);
    rec.length  = (pos == POS_MAX) ? POS_MAX : pos + 16'd1;
    rec.proto   = proto_seen_next;
    rec.src     = source_seen_next;
    rec.dst     = dest_seen_next;
    rec.ports   = ports_seen_next;
    rec.pclass  = item.packet_class;
    rec.ifindex = item.interface_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      ether_kind     <= '0;
      fragment_word  <= '0;
      version_length <= '0;
      proto_seen     <= '0;
      source_seen    <= '0;
      dest_seen      <= '0;
      ports_seen     <= '0;
    end else if (take) begin
      if (item.frame_end) begin
        pos            <= '0;
        ether_kind     <= '0;
        fragment_word  <= '0;
        version_length <= '0;
        proto_seen     <= '0;
        source_seen    <= '0;
        dest_seen      <= '0;
        ports_seen     <= '0;
      end else begin
        if (pos != POS_MAX) begin
          pos <= pos + 16'd1;
        end
        ether_kind     <= ether_kind_next;
        fragment_word  <= fragment_word_next;
        version_length <= version_length_next;
        proto_seen     <= proto_seen_next;
        source_seen    <= source_seen_next;
        dest_seen      <= dest_seen_next;
        ports_seen     <= ports_seen_next;
      end
    end
  end

endmodule

// ===== src/iphfe_queue.sv =====
// short queue of finished frame records between front and back parts
module iphfe_queue import iphfe_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  frame_rec_t wr_data,
  input  logic       rd,
  output frame_rec_t rd_data,
  output logic       is_full,
  output logic       is_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  frame_rec_t        slots [DEPTH];
  logic [AW-1:0]     wptr, rptr;
  logic [AW:0]       count;

  assign is_full  = (count == (AW+1)'(DEPTH));
  assign is_empty = (count == '0);
  assign rd_data  = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == LAST) ? '0 : wptr + AW'(1);
      end
      if (rd) begin
        rptr <= (rptr == LAST) ? '0 : rptr + AW'(1);
      end
      if (wr && !rd) begin
        count <= count + (AW+1)'(1);
      end else if (rd && !wr) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

// ===== src/iphfe_emit.sv =====
// back part: turns frame records into result items in an output register
module iphfe_emit import iphfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       rec_ready,
  input  frame_rec_t rec,
  output logic       rec_take,
  input  logic       pop,
  output logic       empty,
  output out_item_t  result
);

  logic      held;
  out_item_t shaped;

  assign rec_take = rec_ready && (!held || pop);
  assign empty    = !held;

  always_comb begin
    shaped = '0;
    if (rec.keep) begin
      shaped.event_valid     = 1'b1;
      shaped.kept_length     = rec.length;
      shaped.ip_protocol     = rec.proto;
      // gre hides the addresses
      if (rec.proto != PROTO_GRE) begin
        shaped.source_address = rec.src;
        shaped.dest_address   = rec.dst;
      end
      shaped.port_word       = rec.ports;
      shaped.event_class     = rec.pclass;
      shaped.event_interface = rec.ifindex;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take) begin
      result <= shaped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (rec_take) begin
      held <= 1'b1;
    end else if (pop) begin
      held <= 1'b0;
    end
  end

endmodule

// ===== src/ipv4_header_field_extractor_unit.sv =====
// top level of the ipv4 header field extractor
//
// input channel: one frame byte per request with frame_end, packet class and
// interface index; a request is taken when push is high and full is low.
// result channel: one result per frame, on its last byte; the oldest result
// sits on result while empty is low and leaves when pop is high.
// a result shows event_valid for an unfragmented ipv4 frame with protocol,
// addresses (zero for gre), the four bytes after the ip header and the frame
// length; any other frame gives an all-zero result.
// throughput: one byte per cycle while full is low; the header capture is a
// position compare per byte. the request carrying a frame's last byte writes
// its record to the record queue; from there it goes to the output register.
// when the receiver stalls, finished records wait in the output register and
// a QUEUE_DEPTH record queue; bytes keep flowing until that queue fills, then
// full rises until the receiver pops.
// reset (rst, synchronous) empties the queue and output and starts a new frame.
module ipv4_header_field_extractor_unit import iphfe_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic       take;
  logic       rec_push;
  frame_rec_t rec_in, rec_out;
  logic       q_full, q_empty, rec_take;

  assign full = q_full;
  assign take = push && !q_full;

  iphfe_capture u_capture (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .rec_push (rec_push),
    .rec      (rec_in)
  );

  iphfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (rec_push),
    .wr_data  (rec_in),
    .rd       (rec_take),
    .rd_data  (rec_out),
    .is_full  (q_full),
    .is_empty (q_empty)
  );

  iphfe_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .rec_ready (!q_empty),
    .rec       (rec_out),
    .rec_take  (rec_take),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule
